// File: hdl/llc_pkg.sv
// Package for the link frame sequencer: transaction payload types, state type and codes.
// Used by every module under hdl; depends on nothing.
`default_nettype none

package llc_pkg;

  // Operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_TXFAIL = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Command kinds
  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_COND = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;
  localparam logic [1:0] KIND_WAIT = 2'd3;

  // Request kinds
  localparam logic [1:0] REQ_IFRAME = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;

  // Result actions
  localparam logic [1:0] ACT_TX = 2'd0;
  localparam logic [1:0] ACT_OK = 2'd1;
  localparam logic [1:0] ACT_ERR = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_REQ = 3'd1;
  localparam logic [2:0] ST_SEND_FAIL = 3'd2;
  localparam logic [2:0] ST_CRC_ERR = 3'd3;
  localparam logic [2:0] ST_BAD_FRAME = 3'd4;
  localparam logic [2:0] ST_RETRIES = 3'd5;

  // Control byte classification
  localparam logic [7:0] HDR_MASK_I = 8'hC0;
  localparam logic [7:0] HDR_I = 8'h80;
  localparam logic [7:0] HDR_MASK_SU = 8'hE0;
  localparam logic [7:0] HDR_S = 8'hC0;
  localparam logic [7:0] HDR_U = 8'hE0;
  localparam logic [7:0] HDR_RESET = 8'hF9;
  localparam logic [4:0] HDR_RR_TOP = 5'b11000;

  // Supervisory frame types (header bits 4:3)
  localparam logic [1:0] S_RR = 2'd0;
  localparam logic [1:0] S_REJ = 2'd1;
  localparam logic [1:0] S_RNR = 2'd2;

  localparam logic [2:0] AttemptLimitReset = 3'd3;
  localparam int unsigned ResFifoDepth = 4;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] command_kind;
    logic [1:0] request_kind;
    logic [7:0] rx_header;
    logic       rx_crc_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] tx_header;
    logic       tx_with_payload;
    logic [2:0] status;
    logic [2:0] seq_send;
    logic [2:0] seq_recv;
    logic       last;
  } res_item_t;

  typedef struct packed {
    logic [2:0] send_seq;
    logic [2:0] recv_seq;
    logic [2:0] attempts;
    logic       busy;
    logic [7:0] saved_header;
    logic [1:0] saved_kind;
    logic       resend_pending;
  } llc_state_t;

  // Up to two results pushed into the result queue per item
  typedef struct packed {
    logic [1:0] cnt;
    res_item_t  d0;
    res_item_t  d1;
  } res_push_t;

endpackage

`default_nettype wire

// File: hdl/llc_link_frame_sequencer.sv
// Path: an item is registered in in_q, then its results are written into the result queue;
// the first result is offered from there. A queue without room for two results holds the item in in_q.
// Throughput: one item per cycle while the queue has room for two results; the output
// side drains one result per cycle while out_ready_i is high, pacing two-result items.
// Reset: asynchronous, active low; sequence numbers, attempts and queue clear, limit is 3.
// Top level of the link frame sequencer; uses llc_pkg, llc_step and llc_res_fifo.
`default_nettype none

module llc_link_frame_sequencer import llc_pkg::*; #(
  parameter int unsigned ResDepth = ResFifoDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_item_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output res_item_t       out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_data_i
);

  in_item_t   in_q;
  logic       in_valid_q;
  llc_state_t st_q, st_d;
  logic [2:0] limit_q;
  res_push_t  step_push, push;
  logic       space2, consume;

  assign consume = in_valid_q && space2;
  assign in_ready_o = !in_valid_q || consume;
  assign cfg_ready_o = 1'b1;

  llc_step u_step (
    .item_i (in_q),
    .st_i   (st_q),
    .limit_i(limit_q),
    .st_o   (st_d),
    .push_o (step_push)
  );

  always_comb begin
    push = step_push;
    if (!consume) push.cnt = 2'd0;
  end

  llc_res_fifo #(.Depth(ResDepth)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space2_o   (space2),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      limit_q <= AttemptLimitReset;
      st_q <= '{send_seq: '0, recv_seq: '0, attempts: '0, busy: 1'b0,
                saved_header: '0, saved_kind: '0, resend_pending: 1'b1};
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (consume) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

endmodule

`default_nettype wire

// File: hdl/llc_step.sv
// Combinational step logic: next protocol state and up to two results for one item.
// Depends on llc_pkg.
`default_nettype none

module llc_step import llc_pkg::*; (
  input  wire in_item_t   item_i,
  input  wire llc_state_t st_i,
  input  wire logic [2:0] limit_i,
  output llc_state_t      st_o,
  output res_push_t       push_o
);

  logic [7:0] hdr;
  logic [2:0] att;
  logic       count_attempt;
  logic [1:0] n;
  res_item_t  r0;
  res_item_t  r1;

  always_comb begin
    st_o = st_i;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    hdr = '0;
    att = '0;
    count_attempt = 1'b0;

    case (item_i.operation)
      OP_START: begin
        st_o.busy = 1'b0;
        if (item_i.command_kind != KIND_WAIT && item_i.request_kind != REQ_IFRAME &&
            item_i.request_kind != REQ_RESET) begin
          n = 2'd1;
          r0.action = ACT_ERR;
          r0.status = ST_BAD_REQ;
        end else begin
          if (item_i.command_kind != KIND_WAIT) begin
            if (item_i.request_kind == REQ_IFRAME) begin
              hdr = {2'b10, st_i.send_seq, st_i.recv_seq};
              st_o.send_seq = st_i.send_seq + 3'd1;
            end else begin
              hdr = HDR_RESET;
            end
            n = 2'd1;
            r0.action = ACT_TX;
            r0.tx_header = hdr;
            r0.tx_with_payload = 1'b1;
          end
          st_o.busy = 1'b1;
          st_o.attempts = '0;
          st_o.saved_kind = item_i.command_kind;
          st_o.saved_header = hdr;
          st_o.resend_pending = 1'b1;
        end
      end
      OP_FRAME: begin
        if (st_i.busy) begin
          if (!item_i.rx_crc_ok) begin
            n = 2'd1;
            r0.action = ACT_ERR;
            r0.status = ST_CRC_ERR;
            st_o.busy = 1'b0;
          end else if ((item_i.rx_header & HDR_MASK_I) == HDR_I) begin
            if (item_i.rx_header[5:3] == st_i.recv_seq) begin
              // in-sequence I-frame: ack with RR, then done
              st_o.recv_seq = item_i.rx_header[5:3] + 3'd1;
              st_o.send_seq = item_i.rx_header[2:0];
              st_o.busy = 1'b0;
              n = 2'd2;
              r0.action = ACT_TX;
              r0.tx_header = {HDR_RR_TOP, st_o.recv_seq};
              r1.action = ACT_OK;
            end else begin
              st_o.resend_pending = 1'b1;
              count_attempt = 1'b1;
            end
          end else if ((item_i.rx_header & HDR_MASK_SU) == HDR_S) begin
            case (item_i.rx_header[4:3])
              S_RR: begin
                st_o.send_seq = item_i.rx_header[2:0];
                if (st_i.saved_kind == KIND_EVENT) begin
                  n = 2'd1;
                  r0.action = ACT_OK;
                  st_o.busy = 1'b0;
                end else begin
                  st_o.resend_pending = 1'b0;
                  count_attempt = 1'b1;
                end
              end
              S_REJ, S_RNR: begin
                st_o.resend_pending = 1'b1;
                count_attempt = 1'b1;
              end
              default: begin
                // SREJ is not supported
                n = 2'd1;
                r0.action = ACT_ERR;
                r0.status = ST_BAD_FRAME;
                st_o.busy = 1'b0;
              end
            endcase
          end else if ((item_i.rx_header & HDR_MASK_SU) == HDR_U) begin
            n = 2'd1;
            r0.action = ACT_OK;
            st_o.busy = 1'b0;
          end else begin
            n = 2'd1;
            r0.action = ACT_ERR;
            r0.status = ST_BAD_FRAME;
            st_o.busy = 1'b0;
          end
        end
      end
      OP_TXFAIL: begin
        if (st_i.busy) begin
          n = 2'd1;
          r0.action = ACT_ERR;
          r0.status = ST_SEND_FAIL;
          st_o.busy = 1'b0;
        end
      end
      default: begin
        st_o.send_seq = '0;
        st_o.recv_seq = '0;
      end
    endcase

    if (count_attempt) begin
      att = st_i.attempts + 3'd1;
      st_o.attempts = att;
      if (att >= limit_i) begin
        n = 2'd1;
        r0.action = ACT_ERR;
        r0.status = ST_RETRIES;
        st_o.busy = 1'b0;
      end else if (st_o.resend_pending && st_i.saved_kind != KIND_WAIT) begin
        n = 2'd1;
        r0.action = ACT_TX;
        r0.tx_header = st_i.saved_header;
        r0.tx_with_payload = 1'b1;
      end
    end

    r0.seq_send = st_o.send_seq;
    r0.seq_recv = st_o.recv_seq;
    r0.last = (n == 2'd1);
    r1.seq_send = st_o.send_seq;
    r1.seq_recv = st_o.recv_seq;
    r1.last = 1'b1;

    push_o.cnt = n;
    push_o.d0 = r0;
    push_o.d1 = r1;
  end

endmodule

`default_nettype wire

// File: hdl/llc_res_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per transaction.
// Depends on llc_pkg.
`default_nettype none

module llc_res_fifo import llc_pkg::*; #(
  parameter int unsigned Depth = ResFifoDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire res_push_t push_i,
  output logic           space2_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output res_item_t      out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] MaxFill2 = CntW'(Depth - 2);

  res_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    inc = (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_nx = inc(wr_q);
  assign pop = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o = mem_q[rd_q];
  assign space2_o = (cnt_q <= MaxFill2);

  always_comb begin
    wr_d = wr_q;
    if (push_i.cnt == 2'd1) wr_d = wr_nx;
    else if (push_i.cnt == 2'd2) wr_d = inc(wr_nx);
    rd_d = pop ? inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.d0;
    if (push_i.cnt == 2'd2) mem_q[wr_nx] <= push_i.d1;
  end

endmodule

`default_nettype wire

// File: hdl/llc_checker.sv
// Port-level checker for the link frame sequencer, bound to the top level.
// Depends on llc_pkg and llc_link_frame_sequencer.
`default_nettype none

module llc_checker import llc_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire res_item_t out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // a finishing result always closes the item's results
  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action != ACT_TX |-> out_data_o.last)
    else $error("finish result not marked last");

  a_finish_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action != ACT_TX |->
      out_data_o.tx_header == 8'd0 && !out_data_o.tx_with_payload)
    else $error("finish result carries transmit fields");

  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.action == ACT_OK || out_data_o.action == ACT_TX) |->
      out_data_o.status == ST_OK)
    else $error("nonzero status on ok or transmit result");

endmodule

bind llc_link_frame_sequencer llc_checker u_llc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
